// ===== hdl/adrc_pkg.sv =====
// shared types, constants and table builders for the dynamic range compressor
`default_nettype none

package adrc_pkg;

  // envelope and table geometry
  localparam int LOG_TABLE_DEPTH = 64;   // power of two
  localparam int ENV_FRAC_BITS   = 8;
  localparam int LTD_BITS        = $clog2(LOG_TABLE_DEPTH);
  localparam int TI_W            = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int ENV_W           = 16 + ENV_FRAC_BITS;
  localparam int P_W             = $clog2(ENV_W);
  localparam int TAB_W           = 18;
  localparam int LOG_W           = 24;
  localparam int OVER_W          = 22;
  localparam int S_W             = 7;
  localparam int MUL_W           = 32;
  localparam int PROD_W          = 2 * MUL_W;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [14:0] THRESH_RST  = 15'h7FFF & 15'(-2381);
  localparam logic [15:0] SLOPE_RST   = 16'd29127;
  localparam logic [15:0] ATTACK_RST  = 16'd545;
  localparam logic [15:0] RELEASE_RST = 16'd55;

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_SLOPE,
    REG_ATTACK,
    REG_RELEASE
  } adrc_reg_idx_t;

  typedef struct packed {
    logic [14:0] threshold_log;
    logic [15:0] slope;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
  } adrc_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV,
    S_ENV_UPD,
    S_LZD,
    S_LOG_MUL,
    S_LOG_ADD,
    S_CMP,
    S_GAIN_MUL,
    S_GAIN_SPLIT,
    S_EXP_MUL,
    S_EXP_ADD,
    S_OUT_MUL,
    S_ROUND,
    S_OUT
  } adrc_state_t;

  typedef logic [TAB_W-1:0] adrc_tab_t [0:LOG_TABLE_DEPTH];

  // bitwise integer square root, used only while building the tables
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2 fraction table, Q0.16, by repeated squaring
  function automatic adrc_tab_t build_log_tab();
    adrc_tab_t   t;
    logic [63:0] x;
    logic [19:0] y;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH);
      y = '0;
      for (int k = 0; k < 20; k++) begin
        x = (x * x + (64'd1 << 29)) >> 30;
        if (x >= (64'd1 << 31)) begin
          x         = x >> 1;
          y[19 - k] = 1'b1;
        end
      end
      t[i] = TAB_W'((21'(y) + 21'd8) >> 4);
    end
    t[LOG_TABLE_DEPTH] = TAB_W'(65536);
    return t;
  endfunction

  // exp2 table, Q1.16, from a chain of square roots of two
  function automatic adrc_tab_t build_exp_tab();
    adrc_tab_t   t;
    logic [63:0] c [0:24];
    logic [63:0] tt;
    logic [63:0] r;
    c[0] = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) begin
      c[k] = isqrt64(c[k - 1] << 30);
    end
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      tt = (64'(i) << 24) / 64'(LOG_TABLE_DEPTH);
      r  = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        if (tt[24 - k]) begin
          r = (r * c[k] + (64'd1 << 29)) >> 30;
        end
      end
      t[i] = TAB_W'((r + (64'd1 << 13)) >> 14);
    end
    t[LOG_TABLE_DEPTH] = TAB_W'(131072);
    return t;
  endfunction

  localparam adrc_tab_t LOG_TAB = build_log_tab();
  localparam adrc_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== hdl/audio_dynamic_range_compressor.sv =====
// top level: envelope follower, log/exp gain computer and gain stage on one shared multiplier
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | in_valid / in_stall | in_sample_in, in_chunk_end
//   output   | out_valid/out_stall | out_sample_out, out_compressing, out_chunk_last
//   config   | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// the single 32x32 multiplier serves up to five products per item; a new item is accepted only
// once the last is handed to the output register. the exp step is skipped for a reduction with no
// fractional part, the gain steps at or below threshold, and all later steps for a zero envelope.
// reset (rst_n low, synchronous) clears the envelope and loads the default registers.
// a finished item waits in the output register while out_stall is high; the
// sequencer holds in its last step until that register is free.
`default_nettype none

module audio_dynamic_range_compressor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_sample_in,
  input  logic                        in_chunk_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_sample_out,
  output logic                        out_compressing,
  output logic                        out_chunk_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adrc_pkg::ADDR_W-1:0] paddr,
  input  logic [adrc_pkg::DATA_W-1:0] pwdata,
  output logic [adrc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import adrc_pkg::*;

  localparam logic [ENV_W-1:0] ENV_MAX   = ENV_W'(1) << (ENV_W - 1);
  localparam logic [S_W-1:0]   SHIFT_MAX = S_W'(40);

  adrc_cfg_t cfg;

  // control and payload registers
  adrc_state_t          state_r,     state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ENV_W-1:0]     env_r,       env_nxt;
  logic [15:0]          sample_r,    sample_nxt;
  logic [15:0]          mag_r,       mag_nxt;
  logic                 neg_r,       neg_nxt;
  logic                 last_r,      last_nxt;
  logic [P_W-1:0]       p_r,         p_nxt;
  logic [LTD_BITS-1:0]  idx_r,       idx_nxt;
  logic [30:0]          frac_r,      frac_nxt;
  logic signed [LOG_W-1:0] log_r,    log_nxt;
  logic [OVER_W-1:0]    over_r,      over_nxt;
  logic [S_W-1:0]       s_r,         s_nxt;
  logic [TAB_W-1:0]     x_r,         x_nxt;
  logic [PROD_W-1:0]    prod_r,      prod_nxt;
  logic [15:0]          res_r,       res_nxt;
  logic                 comp_r,      comp_nxt;
  logic [15:0]          out_sample_r, out_sample_nxt;
  logic                 out_comp_r,  out_comp_nxt;
  logic                 out_last_r,  out_last_nxt;

  // shared multiplier operands
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;

  // envelope helpers
  logic [ENV_W-1:0] a_env;
  logic [ENV_W-1:0] d_env;
  logic             env_up;

  // table addresses
  logic [TI_W-1:0] lo_idx;
  logic [TI_W-1:0] hi_idx;

  logic in_acc;

  adrc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_compressing = out_comp_r;
  assign out_chunk_last  = out_last_r;

  // envelope target and distance
  assign a_env  = ENV_W'(mag_r) << ENV_FRAC_BITS;
  assign env_up = a_env > env_r;
  assign d_env  = env_up ? (a_env - env_r) : (env_r - a_env);

  assign lo_idx = TI_W'(idx_r);
  assign hi_idx = lo_idx + TI_W'(1);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ENV: begin
        mul_a = MUL_W'(env_up ? cfg.attack_coeff : cfg.release_coeff);
        mul_b = MUL_W'(d_env);
      end
      S_LOG_MUL: begin
        mul_a = MUL_W'(LOG_TAB[hi_idx] - LOG_TAB[lo_idx]);
        mul_b = MUL_W'(frac_r);
      end
      S_GAIN_MUL: begin
        mul_a = MUL_W'(cfg.slope);
        mul_b = MUL_W'(over_r);
      end
      S_EXP_MUL: begin
        mul_a = MUL_W'(EXP_TAB[hi_idx] - EXP_TAB[lo_idx]);
        mul_b = MUL_W'(frac_r);
      end
      S_OUT_MUL: begin
        mul_a = MUL_W'(mag_r);
        mul_b = MUL_W'(x_r);
      end
      default: ;
    endcase
  end

  // sequencer and datapath next values
  always_comb begin
    logic [ENV_W-1:0]        delta;
    logic [P_W-1:0]          p;
    logic [ENV_W-1:0]        norm;
    logic [30:0]             f31;
    logic [PROD_W-1:0]       rnd_w;
    logic [TAB_W-1:0]        fr;
    logic signed [P_W:0]     expo;
    logic signed [LOG_W:0]   over_s;
    logic [PROD_W-1:0]       gr_w;
    logic [15:0]             g;
    logic [15:0]             h;
    logic [7:0]              sh_rnd;
    logic [7:0]              sh_q;
    logic [16:0]             q;
    logic signed [17:0]      sres;

    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    env_nxt        = env_r;
    sample_nxt     = sample_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    last_nxt       = last_r;
    p_nxt          = p_r;
    idx_nxt        = idx_r;
    frac_nxt       = frac_r;
    log_nxt        = log_r;
    over_nxt       = over_r;
    s_nxt          = s_r;
    x_nxt          = x_r;
    res_nxt        = res_r;
    comp_nxt       = comp_r;
    out_sample_nxt = out_sample_r;
    out_comp_nxt   = out_comp_r;
    out_last_nxt   = out_last_r;
    prod_nxt       = PROD_W'(mul_a) * PROD_W'(mul_b);

    delta  = '0;
    p      = '0;
    norm   = '0;
    f31    = '0;
    rnd_w  = '0;
    fr     = '0;
    expo   = '0;
    over_s = '0;
    gr_w   = '0;
    g      = '0;
    h      = '0;
    sh_rnd = '0;
    sh_q   = '0;
    q      = '0;
    sres   = '0;

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_sample_in;
          neg_nxt    = in_sample_in[15];
          mag_nxt    = in_sample_in[15] ? 16'(16'd0 - in_sample_in) : in_sample_in;
          last_nxt   = in_chunk_end;
          comp_nxt   = 1'b0;
          state_nxt  = S_ENV;
        end
      end

      S_ENV: begin
        state_nxt = S_ENV_UPD;
      end

      // envelope moves toward the magnitude by the rounded product
      S_ENV_UPD: begin
        delta     = ENV_W'((prod_r + PROD_W'(32768)) >> 16);
        env_nxt   = env_up ? (env_r + delta) : (env_r - delta);
        state_nxt = S_LZD;
      end

      // leading-one detect and normalise
      S_LZD: begin
        for (int k = 0; k < ENV_W; k++) begin
          if (env_r[k]) begin
            p = P_W'(k);
          end
        end
        norm     = env_r << (P_W'(ENV_W - 1) - p);
        f31      = 31'(norm[ENV_W-2:0]) << (32 - ENV_W);
        p_nxt    = p;
        idx_nxt  = f31[30 -: LTD_BITS];
        frac_nxt = f31 << LTD_BITS;
        if (env_r == '0) begin
          res_nxt   = sample_r;
          comp_nxt  = 1'b0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_LOG_MUL;
        end
      end

      S_LOG_MUL: begin
        state_nxt = S_LOG_ADD;
      end

      // log2 of envelope relative to full scale, in q.16
      S_LOG_ADD: begin
        fr        = LOG_TAB[lo_idx] + TAB_W'((prod_r + (PROD_W'(1) << 30)) >> 31);
        expo      = $signed({1'b0, p_r}) - $signed((P_W+1)'(ENV_W - 1));
        log_nxt   = (LOG_W'(expo) <<< 16) + $signed(LOG_W'(fr));
        state_nxt = S_CMP;
      end

      // distance above threshold
      S_CMP: begin
        over_s   = (LOG_W+1)'(log_r) - ((LOG_W+1)'($signed(cfg.threshold_log)) <<< 6);
        over_nxt = OVER_W'(over_s);
        if (!over_s[LOG_W] && (over_s != '0)) begin
          comp_nxt  = 1'b1;
          state_nxt = S_GAIN_MUL;
        end else begin
          comp_nxt  = 1'b0;
          res_nxt   = sample_r;
          state_nxt = S_OUT;
        end
      end

      S_GAIN_MUL: begin
        state_nxt = S_GAIN_SPLIT;
      end

      // split gain reduction into whole shift and fractional part
      S_GAIN_SPLIT: begin
        gr_w = (prod_r + PROD_W'(32768)) >> 16;
        g    = gr_w[15:0];
        h    = 16'(17'h10000 - {1'b0, g});
        if (g == '0) begin
          x_nxt     = TAB_W'(65536);
          s_nxt     = S_W'(gr_w >> 16);
          state_nxt = S_OUT_MUL;
        end else begin
          idx_nxt   = h[15 -: LTD_BITS];
          frac_nxt  = 31'(16'(h << LTD_BITS));
          s_nxt     = S_W'(gr_w >> 16) + S_W'(1);
          state_nxt = S_EXP_MUL;
        end
      end

      S_EXP_MUL: begin
        state_nxt = S_EXP_ADD;
      end

      // interpolated exp2 of one minus the fractional part
      S_EXP_ADD: begin
        x_nxt     = EXP_TAB[lo_idx] + TAB_W'((prod_r + PROD_W'(32768)) >> 16);
        state_nxt = S_OUT_MUL;
      end

      S_OUT_MUL: begin
        state_nxt = S_ROUND;
      end

      // round, shift, restore sign and saturate
      S_ROUND: begin
        sh_rnd = 8'(s_r) + 8'd15;
        sh_q   = 8'(s_r) + 8'd16;
        rnd_w  = prod_r + (PROD_W'(1) << sh_rnd);
        q      = (s_r > SHIFT_MAX) ? 17'd0 : 17'(rnd_w >> sh_q);
        sres   = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (sres > 18'sd32767) begin
          res_nxt = 16'h7FFF;
        end else if (sres < -18'sd32768) begin
          res_nxt = 16'h8000;
        end else begin
          res_nxt = 16'(sres);
        end
        state_nxt = S_OUT;
      end

      // hand the item to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_sample_nxt = res_r;
          out_comp_nxt   = comp_r;
          out_last_nxt   = last_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      env_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      env_r       <= env_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    last_r       <= last_nxt;
    p_r          <= p_nxt;
    idx_r        <= idx_nxt;
    frac_r       <= frac_nxt;
    log_r        <= log_nxt;
    over_r       <= over_nxt;
    s_r          <= s_nxt;
    x_r          <= x_nxt;
    prod_r       <= prod_nxt;
    res_r        <= res_nxt;
    comp_r       <= comp_nxt;
    out_sample_r <= out_sample_nxt;
    out_comp_r   <= out_comp_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // an accepted item always starts with the envelope product
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ENV))
    else $error("accepted item did not start the envelope step");

  // envelope never passes full scale
  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ENV_MAX)
    else $error("envelope above full scale");

  // a result appears only from the hand-off step
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("output became valid outside the hand-off step");
`endif

endmodule

`default_nettype wire

// ===== hdl/adrc_regs.sv =====
// configuration registers behind the apb-style port
`default_nettype none

module adrc_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [adrc_pkg::ADDR_W-1:0] paddr,
  input  logic [adrc_pkg::DATA_W-1:0] pwdata,
  output logic [adrc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output adrc_pkg::adrc_cfg_t        cfg
);
  import adrc_pkg::*;

  adrc_cfg_t     cfg_r;
  adrc_reg_idx_t idx;
  logic          wr_en;

  assign idx    = adrc_reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_log <= THRESH_RST;
      cfg_r.slope         <= SLOPE_RST;
      cfg_r.attack_coeff  <= ATTACK_RST;
      cfg_r.release_coeff <= RELEASE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD: cfg_r.threshold_log <= pwdata[14:0];
        REG_SLOPE:     cfg_r.slope         <= pwdata[15:0];
        REG_ATTACK:    cfg_r.attack_coeff  <= pwdata[15:0];
        REG_RELEASE:   cfg_r.release_coeff <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  // read back, threshold sign-extended
  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = DATA_W'($signed(cfg_r.threshold_log));
      REG_SLOPE:     prdata = DATA_W'(cfg_r.slope);
      REG_ATTACK:    prdata = DATA_W'(cfg_r.attack_coeff);
      REG_RELEASE:   prdata = DATA_W'(cfg_r.release_coeff);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire
